@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant");

// Implication checked in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

@@ hw/rtl/ledp_pkg.sv @@
package ledp_pkg;

    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 3;
    localparam int LEDIDX_W   = 7;
    localparam int CHAN_W     = 12;
    localparam int LVL_W      = 4;
    localparam int DATA_W     = 48;   // led_index + 3 channels + battery_on + level

    // only the first DEC_LEN characters of a command take part in decoding
    localparam int DEC_LEN        = 15;
    localparam int LINE_BYTES_DEF = 16;
    localparam int LED_COUNT      = 16;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 4'd9;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BRIGHT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BATT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RGB    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_HSV    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REJECT = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DROP   = 3'd6;

    // character k of the current command, NUL past the end
    typedef logic [DEC_LEN-1:0][BYTE_W-1:0] ledp_chars_t;

    typedef struct packed {
        logic term;       // incoming byte ends a command
        logic overflow;   // command ran past the store
        logic empty;      // nothing stored
    } ledp_frame_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [LVL_W-1:0]    level;
        logic                battery_on;
        logic [CHAN_W-1:0]   chan_c;
        logic [CHAN_W-1:0]   chan_b;
        logic [CHAN_W-1:0]   chan_a;
        logic [LEDIDX_W-1:0] led_index;
    } ledp_result_t;

endpackage

@@ hw/rtl/ledp_framer.sv @@
module ledp_framer
    import ledp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    output ledp_chars_t       chars,
    output ledp_frame_t       status
);

    localparam int STORE_CAP   = LINE_BYTES - 1;
    localparam int STORE_DEPTH = (STORE_CAP < DEC_LEN) ? STORE_CAP : DEC_LEN;
    localparam int CNT_W       = $clog2(LINE_BYTES);

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic [STORE_DEPTH-1:0][BYTE_W-1:0] store_reg;

    logic is_term;
    logic full;
    logic store_en;

    assign is_term  = (in_byte == CH_NUL) || (in_byte == CH_LF);
    assign full     = (fill_reg == CNT_W'(STORE_CAP));
    assign store_en = accept && !is_term && !ovf_reg && !full;

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            if (is_term) begin
                fill_next = '0;
                ovf_next  = 1'b0;
            end else if (ovf_reg || full) begin
                ovf_next = 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    // characters past the decode window are counted but not kept
    always_ff @(posedge aclk) begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (store_en && (fill_reg == CNT_W'(k))) begin
                store_reg[k] <= in_byte;
            end
        end
    end

    always_comb begin
        chars = '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (fill_reg > CNT_W'(k)) begin
                chars[k] = store_reg[k];
            end
        end
    end

    always_comb begin
        status.term     = is_term;
        status.overflow = ovf_reg;
        status.empty    = (fill_reg == '0);
    end

endmodule

@@ hw/rtl/ledp_decode.sv @@
module ledp_decode
    import ledp_pkg::*;
(
    input  ledp_chars_t      chars,
    input  logic             overflow,
    input  logic [LVL_W-1:0] level_in,
    output ledp_result_t     result,
    output logic             level_wr
);

    localparam logic [8*BYTE_W-1:0] TXT_CLEARALL = "CLEARALL";
    localparam logic [3*BYTE_W-1:0] TXT_LED      = "LED";
    localparam logic [4*BYTE_W-1:0] TXT_BRIG     = "BRIG";
    localparam logic [5*BYTE_W-1:0] TXT_BATEN    = "BATEN";
    localparam logic [3*BYTE_W-1:0] TXT_RGB      = "RGB";
    localparam logic [3*BYTE_W-1:0] TXT_HSV      = "HSV";
    localparam logic [BYTE_W-1:0]   CH_R         = "R";
    localparam logic [BYTE_W-1:0]   CH_ZERO      = "0";
    localparam logic [BYTE_W-1:0]   CH_ONE       = "1";
    localparam logic [BYTE_W-1:0]   CH_NINE      = "9";

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_nib(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (is_digit(c)) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic                is_clr, is_led, is_brig, brig_ok, is_bat, bat_ok;
    logic                idx_ok, is_rgb, is_hsv, hex_ok;
    logic [LEDIDX_W-1:0] idx_val;
    logic [4:0]          nib [6];
    logic [BYTE_W-1:0]   byte_a, byte_b, byte_c;
    logic [LVL_W-1:0]    new_level;

    always_comb begin
        for (int n = 0; n < 6; n++) begin
            nib[n] = hex_nib(chars[8 + n]);
        end
    end

    assign is_clr = ({chars[0], chars[1], chars[2], chars[3], chars[4], chars[5],
                      chars[6], chars[7]} == TXT_CLEARALL) &&
                    ((chars[8] == CH_NUL) || (chars[8] == CH_R && chars[9] == CH_NUL));
    assign is_led  = ({chars[0], chars[1], chars[2]} == TXT_LED);
    assign is_brig = ({chars[3], chars[4], chars[5], chars[6]} == TXT_BRIG);
    assign brig_ok = is_digit(chars[7]) && (chars[8] == CH_NUL);
    assign is_bat  = ({chars[3], chars[4], chars[5], chars[6], chars[7]} == TXT_BATEN);
    assign bat_ok  = ((chars[8] == CH_ZERO) || (chars[8] == CH_ONE)) && (chars[9] == CH_NUL);

    assign idx_val = {3'b0, chars[3][3:0]} * 7'd10 + {3'b0, chars[4][3:0]};
    assign idx_ok  = is_digit(chars[3]) && is_digit(chars[4]) &&
                     (idx_val < LEDIDX_W'(LED_COUNT));
    assign is_rgb  = ({chars[5], chars[6], chars[7]} == TXT_RGB);
    assign is_hsv  = ({chars[5], chars[6], chars[7]} == TXT_HSV);
    assign hex_ok  = nib[0][4] && nib[1][4] && nib[2][4] && nib[3][4] && nib[4][4] &&
                     nib[5][4] && (chars[14] == CH_NUL);

    assign byte_a    = {nib[0][3:0], nib[1][3:0]};
    assign byte_b    = {nib[2][3:0], nib[3][3:0]};
    assign byte_c    = {nib[4][3:0], nib[5][3:0]};
    assign new_level = chars[7][3:0];

    always_comb begin
        result   = '0;
        level_wr = 1'b0;
        result.action = ACT_REJECT;
        if (overflow) begin
            result.action = ACT_DROP;
        end else if (is_clr) begin
            result.action = ACT_CLEAR;
        end else if (is_led) begin
            if (is_brig) begin
                if (brig_ok) begin
                    result.action = ACT_BRIGHT;
                    level_wr      = 1'b1;
                end
            end else if (is_bat) begin
                if (bat_ok) begin
                    result.action     = ACT_BATT;
                    result.battery_on = (chars[8] == CH_ONE);
                end
            end else if (idx_ok && (is_rgb || is_hsv) && hex_ok) begin
                // hue is scaled like the other channels in HSV mode
                result.action    = is_rgb ? ACT_RGB : ACT_HSV;
                result.led_index = idx_val;
                result.chan_a    = {4'b0, byte_a} * {8'b0, level_in};
                result.chan_b    = {4'b0, byte_b} * {8'b0, level_in};
                result.chan_c    = {4'b0, byte_c} * {8'b0, level_in};
            end
        end
        result.level = level_wr ? new_level : level_in;
    end

endmodule

@@ hw/rtl/ledp_out_buf.sv @@
`include "assert_macros.svh"

module ledp_out_buf
    import ledp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  ledp_result_t push_data,
    output logic         in_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output ledp_result_t m_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    ledp_result_t main_reg, skid_reg;
    logic         take;

    assign take     = !main_valid_reg || m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    `ASSERT_IMPL(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `ASSERT_IMPL(a_no_push_when_full, aclk, aresetn, push, !skid_valid_reg)

endmodule

@@ hw/rtl/led_text_command_parser_top.sv @@
// A result is registered in the output buffer when its terminator byte is accepted
// and is held there while an earlier result waits on m_tready. Throughput: one byte
// per cycle while s_tready is high; decode is one pass from the line store to output.
// A two-entry output buffer lets s_tready stay high while one result waits on m_tready.
// Reset (aresetn low, synchronous): empty line, no overflow, level 9, no result pending.
// The line store itself is not cleared; only characters below the fill count are read.
`include "assert_macros.svh"

module led_text_command_parser_top
    import ledp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input item
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    // result item
    output logic              m_tvalid,
    input  logic              m_tready,
    // [6:0] led_index, [18:7] chan_a, [30:19] chan_b, [42:31] chan_c,
    // [43] battery_on, [47:44] level
    output logic [DATA_W-1:0] m_tdata,
    output logic [ACT_W-1:0]  m_tuser    // [2:0] action
);

    logic             s_fire;
    logic             push;
    logic             level_wr;
    logic [LVL_W-1:0] level_reg;
    ledp_chars_t      chars;
    ledp_frame_t      status;
    ledp_result_t     dec_res;
    ledp_result_t     out_res;

    assign s_fire = s_tvalid && s_tready;

    // Line framing: stores characters, tracks fill count and overflow.
    ledp_framer #(
        .LINE_BYTES(LINE_BYTES)
    ) u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_fire),
        .in_byte (s_tdata),
        .chars   (chars),
        .status  (status)
    );

    // Command decode against the stored line as it stands at the terminator.
    ledp_decode u_decode (
        .chars    (chars),
        .overflow (status.overflow),
        .level_in (level_reg),
        .result   (dec_res),
        .level_wr (level_wr)
    );

    // A terminator yields an item unless the line is empty and did not overflow.
    assign push = s_fire && status.term && (status.overflow || !status.empty);

    // Brightness level; the next command already sees a new value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= FULL_LEVEL;
        end else if (push && level_wr) begin
            level_reg <= dec_res.level;
        end
    end

    ledp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (dec_res),
        .in_ready  (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res)
    );

    assign m_tuser = out_res.action;
    assign m_tdata = {out_res.level, out_res.battery_on, out_res.chan_c, out_res.chan_b,
                      out_res.chan_a, out_res.led_index};

    `ASSERT_ALWAYS(a_level_range, aclk, aresetn, level_reg <= FULL_LEVEL)
    `ASSERT_IMPL(a_action_range, aclk, aresetn, m_tvalid, m_tuser <= ACT_DROP)
    `ASSERT_IMPL(a_color_only_fields, aclk, aresetn,
                 m_tvalid && m_tuser != ACT_RGB && m_tuser != ACT_HSV,
                 out_res.led_index == '0 && out_res.chan_a == '0 &&
                 out_res.chan_b == '0 && out_res.chan_c == '0)

endmodule

@@ verif/tb_led_text_command_parser_top.sv @@
module tb_led_text_command_parser_top;
    import ledp_pkg::*;

    localparam int STORE_CAP    = LINE_BYTES_DEF - 1;   // characters held per command
    localparam int RANDOM_BYTES = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 10;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [ACT_W-1:0]  m_tuser;

    led_text_command_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Parser mirror: line buffer, fill count, overflow flag, brightness
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] line_copy [STORE_CAP];
    int                fill_cnt  = 0;
    bit                too_long  = 1'b0;
    logic [LVL_W-1:0]  bright    = FULL_LEVEL;

    ledp_result_t      pending_cmds[$];     // decoded commands not yet seen on m_*
    int                err_count  = 0;
    int                bytes_sent = 0;
    int                cycle_count = 0;
    bit                no_gaps    = 1'b0;   // both sides run flat out while set

    // positions past the stored text read as NUL
    function automatic logic [BYTE_W-1:0] char_at(int k);
        if (k < fill_cnt && k < STORE_CAP)
            return line_copy[k];
        return CH_NUL;
    endfunction

    function automatic bit is_digit(logic [BYTE_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit starts_with(int start, string txt);
        for (int i = 0; i < txt.len(); i++)
            if (char_at(start + i) != 8'(txt[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int nibble_of(logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    // two hex characters at pos, -1 if either is not hex
    function automatic int hex_pair(int pos);
        int hi;
        int lo;
        hi = nibble_of(char_at(pos));
        lo = nibble_of(char_at(pos + 1));
        if (hi < 0 || lo < 0)
            return -1;
        return hi * 16 + lo;
    endfunction

    // Decode the stored command; r arrives preset to reject.
    function automatic void decode_line(inout ledp_result_t r);
        logic [BYTE_W-1:0] en;
        int idx;
        int ra;
        int rb;
        int rc;
        if (starts_with(0, "CLEARALL") && char_at(8) == CH_NUL) begin
            r.action = ACT_CLEAR;
            return;
        end
        if (starts_with(0, "CLEARALLR") && char_at(9) == CH_NUL) begin
            r.action = ACT_CLEAR;
            return;
        end
        if (!starts_with(0, "LED"))
            return;
        if (starts_with(3, "BRIG")) begin
            if (is_digit(char_at(7)) && char_at(8) == CH_NUL) begin
                bright   = LVL_W'(char_at(7) - "0");
                r.action = ACT_BRIGHT;
            end
            return;
        end
        if (starts_with(3, "BATEN")) begin
            en = char_at(8);
            if ((en == "0" || en == "1") && char_at(9) == CH_NUL) begin
                r.action     = ACT_BATT;
                r.battery_on = (en == "1");
            end
            return;
        end
        if (!is_digit(char_at(3)) || !is_digit(char_at(4)))
            return;
        idx = (char_at(3) - "0") * 10 + (char_at(4) - "0");
        if (idx >= LED_COUNT)
            return;
        if (!starts_with(5, "RGB") && !starts_with(5, "HSV"))
            return;
        ra = hex_pair(8);
        rb = hex_pair(10);
        rc = hex_pair(12);
        if (ra < 0 || rb < 0 || rc < 0 || char_at(14) != CH_NUL)
            return;
        // hue gets scaled by brightness just like the other two channels
        r.action    = starts_with(5, "RGB") ? ACT_RGB : ACT_HSV;
        r.led_index = LEDIDX_W'(idx);
        r.chan_a    = CHAN_W'(ra * bright);
        r.chan_b    = CHAN_W'(rb * bright);
        r.chan_c    = CHAN_W'(rc * bright);
    endfunction

    // One accepted byte: store it, or at a terminator queue the decoded command.
    function automatic void parse_byte(logic [BYTE_W-1:0] b);
        ledp_result_t r;
        if (b != CH_NUL && b != CH_LF) begin
            if (too_long || fill_cnt >= STORE_CAP)
                too_long = 1'b1;
            else begin
                line_copy[fill_cnt] = b;
                fill_cnt++;
            end
            return;
        end
        if (!too_long && fill_cnt == 0)
            return;                         // empty command, nothing comes out
        r = '0;
        if (too_long)
            r.action = ACT_DROP;
        else begin
            r.action = ACT_REJECT;
            decode_line(r);
        end
        r.level  = bright;
        too_long = 1'b0;
        fill_cnt = 0;
        pending_cmds.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Handshakes are sampled at the falling edge, where every
    // signal already holds the value that the next rising edge will see.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge aclk); while (!s_tready);
        parse_byte(b);
        bytes_sent++;
        @(posedge aclk);
    endtask

    task automatic send_line(input string txt, input logic [BYTE_W-1:0] term);
        for (int i = 0; i < txt.len(); i++)
            send_byte(8'(txt[i]));
        send_byte(term);
    endtask

    // sender holds off until every queued command has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure, compare against oldest entry
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 33);

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(negedge aclk) begin
        ledp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $error("result with nothing pending: action %0d", m_tuser);
                err_count++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("action",     want.action,     m_tuser);
                check_field("led_index",  want.led_index,  m_tdata[6:0]);
                check_field("chan_a",     want.chan_a,     m_tdata[18:7]);
                check_field("chan_b",     want.chan_b,     m_tdata[30:19]);
                check_field("chan_c",     want.chan_c,     m_tdata[42:31]);
                check_field("battery_on", want.battery_on, m_tdata[43]);
                check_field("level",      want.level,      m_tdata[47:44]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic string random_hex(int n);
        string digits;
        string s;
        digits = "0123456789ABCDEFabcdef";
        s = "";
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%c", s, digits[$urandom_range(0, 21)]);
        return s;
    endfunction

    function automatic logic [BYTE_W-1:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    // any byte that does not end a command, top bit included
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_LF)
            b = 8'h0B;
        return b;
    endfunction

    function automatic string random_command(int kind);
        string s;
        int idx;
        if (kind < 25) begin
            if ($urandom_range(0, 1))
                return "CLEARALL";
            return "CLEARALLR";
        end
        if (kind < 40)
            return $sformatf("LEDBRIG%0d", $urandom_range(0, 9));
        if (kind < 50)
            return $sformatf("LEDBATEN%0d", $urandom_range(0, 1));
        if (kind < 92) begin
            // mostly valid indexes, now and then any index up to 99
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                              : $urandom_range(0, LED_COUNT - 1);
            return $sformatf("LED%02d%s%s", idx, $urandom_range(0, 1) ? "RGB" : "HSV",
                             random_hex(6));
        end
        s = "";
        if ($urandom_range(0, 1))
            s = "LED";
        for (int i = $urandom_range(1, 14); i > 0; i--)
            s = $sformatf("%s%c", s, printable());
        return s;
    endfunction

    // overwrite one character, cut a command short, or extend it by one character
    function automatic string break_command(string s);
        case ($urandom_range(0, 2))
            0: s.putc($urandom_range(0, s.len() - 1), printable());
            1: if (s.len() > 1) s = s.substr(0, $urandom_range(0, s.len() - 2));
            default: s = $sformatf("%s%s", s, random_hex(1));
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_clear();
        send_line("CLEARALL", CH_LF);
        send_line("CLEARALLR", CH_NUL);
        send_line("CLEARALLX", CH_LF);      // unknown text
    endtask

    task automatic test_brightness();
        send_line("LEDBRIG0", CH_LF);
        send_line("LED15RGBFFFFFF", CH_LF); // level 0 zeroes every channel
        send_line("LEDBRIG", CH_NUL);       // missing digit, level holds
        send_line("LEDBRIG12", CH_LF);
        send_line("LEDBRIG5", CH_LF);
        send_line("LED04HSVff8001", CH_NUL);
        send_line("LEDBRIG9", CH_LF);
    endtask

    task automatic test_battery();
        send_line("LEDBATEN1", CH_LF);
        send_line("LEDBATEN0", CH_NUL);
        send_line("LEDBATEN2", CH_LF);
        send_line("LEDBATEN11", CH_LF);
    endtask

    task automatic test_color();
        send_line("LED00RGB000000", CH_LF);
        send_line("LED15HSVffFFaa", CH_NUL);
        send_line("LED07XYZ123456", CH_LF); // unknown subcommand
        send_line("LED16RGB123456", CH_LF); // index one past the ring
        send_line("LED99HSV123456", CH_NUL);
        send_line("LEDa1RGB123456", CH_LF);
        send_line("LED03RGB12345G", CH_LF); // bad hex
        send_line("LED03RGB12345", CH_NUL); // short
    endtask

    task automatic test_length();
        send_line("LED01RGB123456Z", CH_LF);    // fills the store exactly
        send_line("LED01RGB1234567X", CH_NUL);  // one over: dropped
        for (int i = 0; i < 20; i++)
            send_byte(8'h80 | 8'($urandom_range(0, 127)));
        send_byte(CH_LF);
        send_line("LE", CH_LF);
    endtask

    task automatic test_empty();
        send_byte(CH_LF);
        send_byte(CH_NUL);
        send_line("CLEARALL", CH_LF);
        send_byte(CH_LF);
        wait_drained();
    endtask

    // Mostly well-formed commands with random content, the rest broken
    // commands and raw noise; a flat-out stretch in the middle, a drain near the end.
    task automatic test_random();
        int start_cnt;
        int kind;
        bit paused;
        string cmd;
        logic [BYTE_W-1:0] term;
        start_cnt = bytes_sent;
        paused    = 1'b0;
        while (bytes_sent - start_cnt < RANDOM_BYTES) begin
            no_gaps = (bytes_sent - start_cnt >= 700) && (bytes_sent - start_cnt < 1000);
            if (!paused && bytes_sent - start_cnt >= 1200) begin
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            term = $urandom_range(0, 1) ? CH_LF : CH_NUL;
            if (kind < 8) begin
                for (int i = $urandom_range(1, 24); i > 0; i--)
                    send_byte(noise_byte());
                send_byte(term);
            end else begin
                cmd = random_command(kind);
                if ($urandom_range(0, 99) < 15)
                    cmd = break_command(cmd);
                send_line(cmd, term);
            end
            if ($urandom_range(0, 99) < 5)
                send_byte(term);            // stray empty command
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_clear();
        test_brightness();
        test_battery();
        test_color();
        test_length();
        test_empty();
        test_random();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
